// ===== rtl/assert_macros.svh =====
// shared assertion macros, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every rising edge out of reset
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// expression must never be true at a rising edge out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/cdu_pkg.sv =====
// ----------------------------------------------------------------------------
// cdu_pkg
// types, constants and helpers shared by the constant divisor unit
// ----------------------------------------------------------------------------
package cdu_pkg;

  // port widths and default word size
  localparam int DATA_BITS     = 32;
  localparam int WORD_BITS_DEF = 32;
  localparam int MAGIC_BITS    = DATA_BITS + 1;
  localparam int SHIFT_BITS    = 6;

  // register indexes of the configuration port
  localparam logic CFG_DIVISOR = 1'b0;
  localparam logic CFG_SIGNED  = 1'b1;

  // opcode values
  localparam logic OP_QUOT = 1'b0;
  localparam logic OP_REM  = 1'b1;

  // kind of divisor, picks the datapath flavor
  typedef enum logic [1:0] {
    DCASE_MAGIC = 2'd0,
    DCASE_UNITY = 2'd1,
    DCASE_POW2  = 2'd2,
    DCASE_ZERO  = 2'd3
  } dcase_e;

  // sequencer states of the magic-number derivation
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_UPRE,
    ST_ULOOP,
    ST_SPRE2,
    ST_SANC,
    ST_SPRE1,
    ST_SLOOP
  } derive_state_e;

  // derived divisor settings handed to the datapath
  typedef struct packed {
    logic [DATA_BITS-1:0]  divisor;
    logic                  smode;
    logic [MAGIC_BITS-1:0] magic;
    logic [SHIFT_BITS-1:0] shift;
    logic                  add;
    dcase_e                dcase;
  } cdu_cfg_t;

  // bit position of a power of two
  function automatic logic [SHIFT_BITS-1:0] log2_pow2(input logic [DATA_BITS-1:0] v);
    logic [SHIFT_BITS-1:0] k;
    k = '0;
    for (int i = 0; i < DATA_BITS; i++) begin
      if (v[i]) begin
        k = SHIFT_BITS'(i);
      end
    end
    return k;
  endfunction

endpackage

// ===== rtl/constant_divisor_unit.sv =====
// ----------------------------------------------------------------------------
// constant_divisor_unit
// divide by a configured invariant divisor through a magic multiply-high
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  in       | to block  | in_valid_i/in_stall_o  | dividend_i, opcode_i
//  out      | from block| out_valid_o/out_stall_i| result_o, divide_error_o
//  cfg      | to block  | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
//  one transaction per cycle, while neither side stalls, through five register
//  stages; the result is valid once it reaches the fifth stage and leaves
//  when the output is not stalled; stage count set by the two multipliers
//  after a register write the input stalls while the magic is derived one
//  bit a cycle; special divisors need no bit loop, other divisors run the
//  unsigned or the longer signed loop; no clearing pass after reset
//  a stalled output holds; earlier stages keep filling until all are full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module constant_divisor_unit #(
  parameter int WORD_BITS = cdu_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [cdu_pkg::DATA_BITS-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cdu_pkg::DATA_BITS-1:0] dividend_i,
  input  logic                          opcode_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cdu_pkg::DATA_BITS-1:0] result_o,
  output logic                          divide_error_o
);
  import cdu_pkg::*;

  cdu_cfg_t cfg;
  logic     busy, pipe_stall;

  // configuration and derivation
  cdu_derive #(
    .WORD_BITS(WORD_BITS)
  ) u_derive (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .cfg_o (cfg),
    .busy_o(busy)
  );

  // datapath
  cdu_pipe #(
    .WORD_BITS(WORD_BITS)
  ) u_pipe (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg),
    .in_valid_i    (in_valid_i && !busy),
    .in_stall_o    (pipe_stall),
    .dividend_i,
    .opcode_i,
    .out_valid_o,
    .out_stall_i,
    .result_o,
    .divide_error_o
  );

  assign in_stall_o = pipe_stall || busy;

  // checks
  `ASSERT_CHK(a_busy_stall, busy |-> in_stall_o, "transaction taken during derivation")
  `ASSERT_NEVER(a_err_result, out_valid_o && divide_error_o && (result_o != '0), "error result not zero")
  `ASSERT_CHK(a_err_case, out_valid_o |-> (divide_error_o == (cfg.dcase == DCASE_ZERO)), "error flag mismatch")

endmodule

// ===== rtl/cdu_derive.sv =====
// ----------------------------------------------------------------------------
// cdu_derive
// configuration registers and bit-serial derivation of magic, shift, add flag
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdu_derive #(
  parameter int WORD_BITS = cdu_pkg::WORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [cdu_pkg::DATA_BITS-1:0] cfg_wdata_i,
  output cdu_pkg::cdu_cfg_t          cfg_o,
  output logic                       busy_o
);
  import cdu_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = $clog2(2 * W + 1);

  logic [DATA_BITS-1:0] div_q, div_d;
  logic                 smode_q, smode_d;
  logic [W:0]           magic_q, magic_d;
  logic [SHIFT_BITS-1:0] shift_q, shift_d;
  logic                 add_q, add_d;
  dcase_e               dcase_q, dcase_d;
  derive_state_e        state_q, state_d;
  logic [PW-1:0]        p_q, p_d;
  logic [W:0]           qa_q, qa_d, ra_q, ra_d, p2_q, p2_d;
  logic [W-1:0]         qb_q, qb_d, rb_q, rb_d, anc_q, anc_d;

  logic [W-1:0] dw, ad;
  logic         dneg;

  assign dw   = div_q[W-1:0];
  assign dneg = dw[W-1];
  assign ad   = dneg ? W'(~dw + W'(1)) : dw;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q   <= DATA_BITS'(1);
      smode_q <= 1'b0;
      magic_q <= (W+1)'(1) << W;
      shift_q <= '0;
      add_q   <= 1'b0;
      dcase_q <= DCASE_UNITY;
      state_q <= ST_IDLE;
    end else begin
      div_q   <= div_d;
      smode_q <= smode_d;
      magic_q <= magic_d;
      shift_q <= shift_d;
      add_q   <= add_d;
      dcase_q <= dcase_d;
      state_q <= state_d;
    end
  end

  // working registers of the sequencer
  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    qa_q  <= qa_d;
    ra_q  <= ra_d;
    p2_q  <= p2_d;
    qb_q  <= qb_d;
    rb_q  <= rb_d;
    anc_q <= anc_d;
  end

  // next state: one long-division step per cycle
  always_comb begin
    logic [W:0]   u_r2, u_r_n, u_q_n, a_r2, a_r_n, a_q_n, p2_n, m_u;
    logic         u_take, a_take, b_take, cont;
    logic [W-1:0] b_r2, b_r_n, b_q_n, delta_u, delta_s, sum, tmod, tval, m_s0, m_s;
    logic [PW-1:0] p_n;

    state_d = state_q;
    div_d   = div_q;
    smode_d = smode_q;
    magic_d = magic_q;
    shift_d = shift_q;
    add_d   = add_q;
    dcase_d = dcase_q;
    p_d     = p_q;
    qa_d    = qa_q;
    ra_d    = ra_q;
    p2_d    = p2_q;
    qb_d    = qb_q;
    rb_d    = rb_q;
    anc_d   = anc_q;

    // unsigned step on 2^p-1 over d
    u_r2   = {ra_q[W-1:0], 1'b1};
    u_take = (u_r2 >= {1'b0, dw});
    u_r_n  = u_take ? u_r2 - {1'b0, dw} : u_r2;
    u_q_n  = {qa_q[W-1:0], u_take};
    // signed step on 2^p over |d|
    a_r2   = {ra_q[W-1:0], 1'b0};
    a_take = (a_r2 >= {1'b0, ad});
    a_r_n  = a_take ? a_r2 - {1'b0, ad} : a_r2;
    a_q_n  = {qa_q[W-1:0], a_take};
    // signed step on 2^p over anc
    b_r2   = {rb_q[W-2:0], 1'b0};
    b_take = (b_r2 >= anc_q);
    b_r_n  = b_take ? b_r2 - anc_q : b_r2;
    b_q_n  = {qb_q[W-2:0], b_take};

    p_n     = p_q + PW'(1);
    p2_n    = (p_n == PW'(W)) ? (W+1)'(1) : {p2_q[W-1:0], 1'b0};
    delta_u = dw - W'(1) - u_r_n[W-1:0];
    delta_s = ad - a_r_n[W-1:0];
    m_u     = u_q_n + (W+1)'(1);
    m_s0    = a_q_n[W-1:0] + W'(1);
    m_s     = dneg ? W'(~m_s0 + W'(1)) : m_s0;
    sum     = ra_q[W-1:0] + W'(dneg);
    tmod    = (sum >= ad) ? sum - ad : sum;
    tval    = (W'(1) << (W - 1)) + W'(dneg);
    cont    = 1'b0;

    case (state_q)
      ST_IDLE: begin
      end
      ST_START: begin
        magic_d = (W+1)'(1) << W;
        shift_d = '0;
        add_d   = 1'b0;
        state_d = ST_IDLE;
        if (dw == '0) begin
          dcase_d = DCASE_ZERO;
        end else if (!smode_q) begin
          if (dw == W'(1)) begin
            dcase_d = DCASE_UNITY;
          end else if ((dw & (dw - W'(1))) == '0) begin
            dcase_d = DCASE_POW2;
            shift_d = log2_pow2(DATA_BITS'(dw));
          end else begin
            dcase_d = DCASE_MAGIC;
            qa_d    = '0;
            ra_d    = '0;
            p_d     = '0;
            state_d = ST_UPRE;
          end
        end else begin
          if (dw == W'(1) || dw == '1) begin
            dcase_d = DCASE_UNITY;
          end else if ((ad & (ad - W'(1))) == '0) begin
            dcase_d = DCASE_POW2;
            shift_d = log2_pow2(DATA_BITS'(ad));
          end else begin
            dcase_d = DCASE_MAGIC;
            qa_d    = '0;
            ra_d    = (W+1)'(1);
            p_d     = '0;
            state_d = ST_SPRE2;
          end
        end
      end
      ST_UPRE: begin
        qa_d = u_q_n;
        ra_d = u_r_n;
        p_d  = p_n;
        if (p_n == PW'(W - 1)) begin
          state_d = ST_ULOOP;
        end
      end
      ST_ULOOP: begin
        qa_d = u_q_n;
        ra_d = u_r_n;
        p_d  = p_n;
        p2_d = p2_n;
        cont = (p_n < PW'(2 * W)) && (p2_n < {1'b0, delta_u});
        if (!cont) begin
          magic_d = m_u;
          add_d   = m_u[W];
          shift_d = SHIFT_BITS'(p_n - PW'(W));
          state_d = ST_IDLE;
        end
      end
      ST_SPRE2: begin
        qa_d = a_q_n;
        ra_d = a_r_n;
        p_d  = p_n;
        if (p_n == PW'(W - 1)) begin
          state_d = ST_SANC;
        end
      end
      ST_SANC: begin
        anc_d   = tval - W'(1) - tmod;
        qb_d    = '0;
        rb_d    = W'(1);
        p_d     = '0;
        state_d = ST_SPRE1;
      end
      ST_SPRE1: begin
        qb_d = b_q_n;
        rb_d = b_r_n;
        p_d  = p_n;
        if (p_n == PW'(W - 1)) begin
          state_d = ST_SLOOP;
        end
      end
      ST_SLOOP: begin
        qa_d = {1'b0, a_q_n[W-1:0]};
        ra_d = {1'b0, a_r_n[W-1:0]};
        qb_d = b_q_n;
        rb_d = b_r_n;
        p_d  = p_n;
        cont = (p_n < PW'(2 * W)) &&
               ((b_q_n < delta_s) || (b_q_n == delta_s && b_r_n == '0));
        if (!cont) begin
          magic_d = {1'b0, m_s};
          add_d   = dneg ^ m_s[W-1];
          shift_d = SHIFT_BITS'(p_n - PW'(W));
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a register write restarts the derivation
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DIVISOR: begin
          div_d   = cfg_wdata_i;
          state_d = ST_START;
        end
        CFG_SIGNED: begin
          smode_d = cfg_wdata_i[0];
          state_d = ST_START;
        end
        default: begin
        end
      endcase
    end
  end

  // outputs
  assign busy_o        = (state_q != ST_IDLE) || cfg_we_i;
  assign cfg_o.divisor = div_q;
  assign cfg_o.smode   = smode_q;
  assign cfg_o.magic   = MAGIC_BITS'(magic_q);
  assign cfg_o.shift   = shift_q;
  assign cfg_o.add     = add_q;
  assign cfg_o.dcase   = dcase_q;

  // checks
  `ASSERT_CHK(a_write_busy, cfg_we_i |=> (state_q != ST_IDLE), "write did not start derivation")
  `ASSERT_CHK(a_shift_range, (state_q == ST_IDLE && dcase_q == DCASE_MAGIC) |-> (shift_q <= SHIFT_BITS'(W)), "post shift out of range")
  `ASSERT_CHK(a_zero_case, (state_q == ST_IDLE && dcase_q == DCASE_ZERO) |-> (dw == '0), "zero case with nonzero divisor")

endmodule

// ===== rtl/cdu_pipe.sv =====
// ----------------------------------------------------------------------------
// cdu_pipe
// five-stage divide datapath: capture, multiply-high, fixup, back-multiply, out
// ----------------------------------------------------------------------------
module cdu_pipe #(
  parameter int WORD_BITS = cdu_pkg::WORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdu_pkg::cdu_cfg_t             cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [cdu_pkg::DATA_BITS-1:0] dividend_i,
  input  logic                          opcode_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [cdu_pkg::DATA_BITS-1:0] result_o,
  output logic                          divide_error_o
);
  import cdu_pkg::*;

  localparam int W = WORD_BITS;

  logic         s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic         en1, en2, en3, en4, en5;
  logic [W-1:0] s1_n_q, s2_n_q, s3_n_q, s4_n_q;
  logic         s1_op_q, s2_op_q, s3_op_q, s4_op_q;
  logic [W-1:0] s2_hi_q, s3_q_q, s4_q_q, s4_qd_q, s5_res_q;
  logic         s5_err_q;

  logic [W-1:0]          dw, mw, q3, res5;
  logic                  dneg;
  logic [SHIFT_BITS-1:0] sh;
  logic signed [W:0]     mul_a, mul_b;
  logic signed [2*W+1:0] prod;
  logic [2*W-1:0]        qd_full;

  assign dw   = cfg_i.divisor[W-1:0];
  assign mw   = cfg_i.magic[W-1:0];
  assign dneg = dw[W-1];
  assign sh   = cfg_i.shift;

  // stage enables: a stage moves when empty or when the next one moves
  assign en5 = !s5_v_q || !out_stall_i;
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_stall_o = !en1;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= in_valid_i;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
      if (en5) s5_v_q <= s4_v_q;
    end
  end

  // multiply-high operands, sign extended in signed mode
  assign mul_a = cfg_i.smode ? $signed({s1_n_q[W-1], s1_n_q}) : $signed({1'b0, s1_n_q});
  assign mul_b = cfg_i.smode ? $signed({mw[W-1], mw}) : $signed({1'b0, mw});
  assign prod  = mul_a * mul_b;

  // quotient fixup after the multiply
  always_comb begin
    logic [W-1:0] n, hi, diff, t, bias, h, h2, qs;
    logic [SHIFT_BITS-1:0] sa;
    n    = s2_n_q;
    hi   = s2_hi_q;
    diff = n - hi;
    t    = W'(diff >> 1) + hi;
    bias = n[W-1] ? ~({W{1'b1}} << sh) : '0;
    h    = cfg_i.add ? (dneg ? hi - n : hi + n) : hi;
    sa   = (sh >= SHIFT_BITS'(W)) ? SHIFT_BITS'(W - 1) : sh;
    h2   = W'($signed(h) >>> sa);
    qs   = W'($signed(n + bias) >>> sh);
    q3   = '0;
    if (!cfg_i.smode) begin
      case (cfg_i.dcase)
        DCASE_UNITY: q3 = n;
        DCASE_POW2:  q3 = n >> sh;
        DCASE_MAGIC: begin
          if (cfg_i.add) begin
            q3 = (sh == '0) ? t : t >> (sh - SHIFT_BITS'(1));
          end else begin
            q3 = hi >> sh;
          end
        end
        default:     q3 = '0;
      endcase
    end else begin
      case (cfg_i.dcase)
        DCASE_UNITY: q3 = dneg ? W'(~n + W'(1)) : n;
        DCASE_POW2:  q3 = dneg ? W'(~qs + W'(1)) : qs;
        DCASE_MAGIC: q3 = h2 + W'(h2[W-1]);
        default:     q3 = '0;
      endcase
    end
  end

  // back-multiply for the remainder
  assign qd_full = s3_q_q * dw;

  // final selection
  assign res5 = (s4_op_q == OP_REM) ? s4_n_q - s4_qd_q : s4_q_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_n_q  <= dividend_i[W-1:0];
      s1_op_q <= opcode_i;
    end
    if (en2) begin
      s2_n_q  <= s1_n_q;
      s2_op_q <= s1_op_q;
      s2_hi_q <= prod[2*W-1:W];
    end
    if (en3) begin
      s3_n_q  <= s2_n_q;
      s3_op_q <= s2_op_q;
      s3_q_q  <= q3;
    end
    if (en4) begin
      s4_n_q  <= s3_n_q;
      s4_op_q <= s3_op_q;
      s4_q_q  <= s3_q_q;
      s4_qd_q <= qd_full[W-1:0];
    end
    if (en5) begin
      s5_err_q <= (cfg_i.dcase == DCASE_ZERO);
      s5_res_q <= (cfg_i.dcase == DCASE_ZERO) ? '0 : res5;
    end
  end

  assign out_valid_o    = s5_v_q;
  assign result_o       = DATA_BITS'(s5_res_q);
  assign divide_error_o = s5_err_q;

endmodule
